FILE: hw/rtl/aawf_pkg.sv
// ----------------------------------------------------------------------------
// aawf_pkg
// shared types and codes for the accumulator alu pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package aawf_pkg;

    typedef enum logic [2:0] {
        FN_ADD = 3'd0,
        FN_ADC = 3'd1,
        FN_SUB = 3'd2,
        FN_SBC = 3'd3,
        FN_AND = 3'd4,
        FN_XOR = 3'd5,
        FN_OR  = 3'd6,
        FN_CP  = 3'd7
    } t_func;

    localparam int unsigned DATA_W = 8;
    localparam int unsigned NIB_W  = 4;

    // flag byte bit positions
    localparam int unsigned FL_S = 7;
    localparam int unsigned FL_Z = 6;
    localparam int unsigned FL_Y = 5;
    localparam int unsigned FL_H = 4;
    localparam int unsigned FL_X = 3;
    localparam int unsigned FL_P = 2;
    localparam int unsigned FL_N = 1;
    localparam int unsigned FL_C = 0;

    typedef struct packed {
        logic [2:0]        func;
        logic [DATA_W-1:0] accumulator;
        logic [DATA_W-1:0] operand;
        logic              carry_in;
    } t_alu_in;

    typedef struct packed {
        logic [DATA_W-1:0] new_accumulator;
        logic [DATA_W-1:0] flags;
    } t_alu_out;

    // stage 1 -> stage 2: low nibble done, logic result ready
    typedef struct packed {
        t_func             func;
        logic [DATA_W-1:0] acc;
        logic [DATA_W-1:0] operand;
        logic              arith;
        logic              sub;
        logic [NIB_W-1:0]  bx_hi;
        logic [NIB_W:0]    lo_sum;
        logic [DATA_W-1:0] logic_res;
    } t_s1;

    // stage 2 -> stage 3: result byte and arithmetic flags
    typedef struct packed {
        t_func             func;
        logic [DATA_W-1:0] acc;
        logic [DATA_W-1:0] operand;
        logic [DATA_W-1:0] res;
        logic              half;
        logic              carry;
        logic              ovf;
        logic              sub;
    } t_s2;

endpackage

`default_nettype wire

FILE: hw/rtl/aawf_lo_stage.sv
// ----------------------------------------------------------------------------
// aawf_lo_stage
// operand conditioning, low nibble add and logic operations
// ----------------------------------------------------------------------------
`default_nettype none

module aawf_lo_stage import aawf_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_ready,
    input  wire t_alu_in i_data,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_s1          o_data
);

    logic              r_valid;
    t_s1               r_data;
    t_s1               n_data;
    t_func             w_func;
    logic              w_sub;
    logic              w_cin;
    logic              w_cx;
    logic [DATA_W-1:0] w_bx;

    assign w_func = t_func'(i_data.func);

    always_comb begin
        w_sub = (w_func inside {FN_SUB, FN_SBC, FN_CP});
        w_cin = (w_func inside {FN_ADC, FN_SBC}) ? i_data.carry_in : 1'b0;
        // subtract as add of the complement, borrow inverted
        w_bx  = w_sub ? ~i_data.operand : i_data.operand;
        w_cx  = w_sub ? ~w_cin : w_cin;

        n_data.func    = w_func;
        n_data.acc     = i_data.accumulator;
        n_data.operand = i_data.operand;
        n_data.arith   = !(w_func inside {FN_AND, FN_XOR, FN_OR});
        n_data.sub     = w_sub;
        n_data.bx_hi   = w_bx[DATA_W-1:NIB_W];
        n_data.lo_sum  = {1'b0, i_data.accumulator[NIB_W-1:0]}
                       + {1'b0, w_bx[NIB_W-1:0]}
                       + {{NIB_W{1'b0}}, w_cx};
        case (w_func)
            FN_AND:  n_data.logic_res = i_data.accumulator & i_data.operand;
            FN_XOR:  n_data.logic_res = i_data.accumulator ^ i_data.operand;
            default: n_data.logic_res = i_data.accumulator | i_data.operand;
        endcase
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

FILE: hw/rtl/aawf_hi_stage.sv
// ----------------------------------------------------------------------------
// aawf_hi_stage
// high nibble add, carry, half carry and overflow
// ----------------------------------------------------------------------------
`default_nettype none

module aawf_hi_stage import aawf_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_s1  i_data,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_s2       o_data
);

    logic           r_valid;
    t_s2            r_data;
    t_s2            n_data;
    logic [NIB_W:0] w_hi_sum;
    logic           w_bx7;

    always_comb begin
        w_hi_sum = {1'b0, i_data.acc[DATA_W-1:NIB_W]}
                 + {1'b0, i_data.bx_hi}
                 + {{NIB_W{1'b0}}, i_data.lo_sum[NIB_W]};
        w_bx7    = i_data.bx_hi[NIB_W-1];

        n_data.func    = i_data.func;
        n_data.acc     = i_data.acc;
        n_data.operand = i_data.operand;
        n_data.sub     = i_data.sub;
        if (i_data.arith) begin
            n_data.res   = {w_hi_sum[NIB_W-1:0], i_data.lo_sum[NIB_W-1:0]};
            // borrows are the inverted carries of the complement add
            n_data.half  = i_data.lo_sum[NIB_W] ^ i_data.sub;
            n_data.carry = w_hi_sum[NIB_W] ^ i_data.sub;
            n_data.ovf   = (i_data.acc[DATA_W-1] == w_bx7)
                        && (w_hi_sum[NIB_W-1] != i_data.acc[DATA_W-1]);
        end else begin
            n_data.res   = i_data.logic_res;
            n_data.half  = (i_data.func == FN_AND);
            n_data.carry = 1'b0;
            n_data.ovf   = 1'b0;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

FILE: hw/rtl/aawf_flag_stage.sv
// ----------------------------------------------------------------------------
// aawf_flag_stage
// sign, zero, parity and copy bits; output register
// ----------------------------------------------------------------------------
`default_nettype none

module aawf_flag_stage import aawf_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_s2  i_data,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_alu_out  o_data
);

    logic              r_valid;
    t_alu_out          r_data;
    t_alu_out          n_data;
    logic              w_cp;
    logic              w_logic;
    logic [DATA_W-1:0] w_xy_src;

    always_comb begin
        w_cp     = (i_data.func == FN_CP);
        w_logic  = (i_data.func inside {FN_AND, FN_XOR, FN_OR});
        w_xy_src = w_cp ? i_data.operand : i_data.res;

        n_data.new_accumulator = w_cp ? i_data.acc : i_data.res;
        n_data.flags[FL_S] = i_data.res[DATA_W-1];
        n_data.flags[FL_Z] = (i_data.res == '0);
        n_data.flags[FL_Y] = w_xy_src[FL_Y];
        n_data.flags[FL_H] = i_data.half;
        n_data.flags[FL_X] = w_xy_src[FL_X];
        n_data.flags[FL_P] = w_logic ? ~(^i_data.res) : i_data.ovf;
        n_data.flags[FL_N] = i_data.sub;
        n_data.flags[FL_C] = i_data.carry;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

FILE: hw/rtl/accumulator_alu_with_flags_core.sv
// ----------------------------------------------------------------------------
// accumulator_alu_with_flags_core
// 8-bit accumulator alu, eight operations, full flag byte, three-stage pipe
// ----------------------------------------------------------------------------
//
//  channel   valid     ready     payload   direction
//  -------   -------   -------   -------   ---------
//  request   i_valid   o_ready   i_data    in  (t_alu_in)
//  result    o_valid   i_ready   o_data    out (t_alu_out)
//
//  one transaction per cycle sustained while i_ready is high; from accept
//  to result valid a transaction passes the three register stages (low nibble, high
//  nibble, flags/output register)
//  reset clears only the stage valid bits; payload registers are not reset
//  each stage loads when it is empty or its successor takes its content, so
//  a stall on i_ready backs up stage by stage and nothing is lost or repeated
//  bubbles are squeezed out: a new request is taken while a result waits
// ----------------------------------------------------------------------------
`default_nettype none

module accumulator_alu_with_flags_core import aawf_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_alu_in  i_data,
    output logic          o_valid,
    input  wire logic     i_ready,
    output t_alu_out      o_data
);

    // stage 1 -> stage 2 handshake
    logic s1_valid;
    logic s1_ready;
    t_s1  s1_data;

    // stage 2 -> stage 3 handshake
    logic s2_valid;
    logic s2_ready;
    t_s2  s2_data;

    // low nibble of the add (subtracts use the complemented operand),
    // logic ops resolved here too
    aawf_lo_stage u_lo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (s1_valid),
        .i_ready (s1_ready),
        .o_data  (s1_data)
    );

    // high nibble, carry/borrow, half carry and overflow
    aawf_hi_stage u_hi (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_data  (s1_data),
        .o_valid (s2_valid),
        .i_ready (s2_ready),
        .o_data  (s2_data)
    );

    // sign, zero, parity, copy bits; compare keeps the accumulator
    aawf_flag_stage u_flag (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .o_ready (s2_ready),
        .i_data  (s2_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule

`default_nettype wire
